// File: hw/rtl/ittl_pkg.sv
// Shared types and constants of the ICMP time-exceeded responder.
// Used by ittl_ctrl, ittl_dp and the top level; depends on nothing.
package ittl_pkg;

  localparam int unsigned CaptureBytesDef = 96;

  localparam logic [6:0] EthLen     = 7'd14;
  localparam logic [6:0] IpLen      = 7'd20;
  localparam logic [6:0] TcpHdrLen  = 7'd20;
  localparam logic [6:0] ShortL4Len = 7'd8;
  localparam logic [6:0] PayloadPos = 7'd42;  // first reply byte taken from the store
  localparam logic [6:0] ReplyLenTcp   = 7'd82;
  localparam logic [6:0] ReplyLenShort = 7'd70;
  localparam logic [6:0] PayLenTcp     = 7'd40;
  localparam logic [6:0] PayLenShort   = 7'd28;
  localparam logic [15:0] MinFrameLen  = 16'd34;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [7:0] IcmpTimeExceeded = 8'd11;
  localparam logic [7:0] ReplyTos  = 8'h2b;
  localparam logic [7:0] ReplyTtl  = 8'd64;
  localparam logic [7:0] VerIhl    = 8'h45;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StPass = 4'b0010,
    StSum  = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic pass_load;   // load a pass verdict into the output register
    logic sum_run;     // checksum pass over the stored payload
    logic emit_start;  // clear pointers before the reply burst
    logic emit_run;    // stream reply bytes
  } cmd_t;

  typedef struct packed {
    logic reply;       // decision on the current (final) byte: send a reply
    logic sum_done;
    logic emit_done;
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/ittl_ctrl.sv
// Controller of the ICMP time-exceeded responder: phase state machine.
// Depends on ittl_pkg; drives commands into ittl_dp.
module ittl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              frame_end_i,
  input  ittl_pkg::status_t status_i,
  output ittl_pkg::cmd_t    cmd_o,
  output logic              in_stall_o
);

  ittl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ittl_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ittl_pkg::StIdle: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && frame_end_i) begin
          state_d = status_i.reply ? ittl_pkg::StSum : ittl_pkg::StPass;
        end
      end
      ittl_pkg::StPass: begin
        if (status_i.out_free) begin
          cmd_o.pass_load = 1'b1;
          state_d = ittl_pkg::StIdle;
        end
      end
      ittl_pkg::StSum: begin
        cmd_o.sum_run = 1'b1;
        if (status_i.sum_done) begin
          cmd_o.emit_start = 1'b1;
          state_d = ittl_pkg::StEmit;
        end
      end
      ittl_pkg::StEmit: begin
        cmd_o.emit_run = 1'b1;
        if (status_i.emit_done) begin
          state_d = ittl_pkg::StIdle;
        end
      end
      default: begin
        state_d = ittl_pkg::StIdle;
      end
    endcase
  end

  assign in_stall_o = (state_q != ittl_pkg::StIdle);

endmodule

// File: hw/rtl/ittl_dp.sv
// Datapath of the ICMP time-exceeded responder: capture store, header fields,
// checksum accumulators, reply byte assembly and output register. Uses ittl_pkg.
module ittl_dp #(
  parameter int unsigned CAPTURE_BYTES = ittl_pkg::CaptureBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ittl_pkg::cmd_t    cmd_i,
  output ittl_pkg::status_t status_o,
  input  logic [7:0]        frame_byte_i,
  input  logic              frame_end_i,
  input  logic              cfg_valid_i,
  input  logic [31:0]       my_address_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              verdict_o,
  output logic [63:0]       reply_word_o,
  output logic [3:0]        valid_bytes_o,
  output logic              last_item_o
);

  localparam int unsigned AW = $clog2(CAPTURE_BYTES);
  localparam logic [15:0] CapLimit = 16'(CAPTURE_BYTES);

  logic [7:0]  mem [CAPTURE_BYTES];
  logic [7:0]  rd_q;
  logic [AW-1:0] rd_addr;

  logic [15:0] count_q;
  logic [15:0] frame_len;
  logic [31:0] my_addr_q;
  logic [7:0]  eth_q [14];
  logic [7:0]  ihl_q, id0_q, id1_q, ttl_q, proto_q;
  logic [7:0]  src_q [4];

  logic        tcp_q;
  logic [6:0]  l4off_q;
  logic [6:0]  idx_q;
  logic        s1_valid_q;
  logic [6:0]  s1_pos_q;
  logic [7:0]  hi_q;
  logic [15:0] ipacc_q, icacc_q;
  logic [63:0] buf_q;

  logic        out_valid_q;
  logic        verdict_q, last_q;
  logic [63:0] word_q;
  logic [3:0]  nbytes_q;

  // Decision logic on the final byte.
  logic       tcp_now, l4_ok;
  logic [6:0] hl, hl_eff, l4len_now, need;
  logic       reply_now;

  assign frame_len = (count_q == 16'hffff) ? count_q : count_q + 16'd1;
  assign tcp_now   = (proto_q == ittl_pkg::ProtoTcp);
  assign l4_ok     = tcp_now || (proto_q == ittl_pkg::ProtoUdp) ||
                     (proto_q == ittl_pkg::ProtoIcmp);
  assign hl        = {1'b0, ihl_q[3:0], 2'b00};
  assign hl_eff    = (hl < ittl_pkg::IpLen) ? ittl_pkg::IpLen : hl;
  assign l4len_now = tcp_now ? ittl_pkg::TcpHdrLen : ittl_pkg::ShortL4Len;
  assign need      = ittl_pkg::EthLen + hl_eff + l4len_now;
  assign reply_now = (frame_len >= ittl_pkg::MinFrameLen) && (eth_q[12] == 8'h08) &&
                     (eth_q[13] == 8'h00) && (ttl_q <= 8'd1) && l4_ok &&
                     ({9'd0, need} <= frame_len);

  logic [6:0] rlen, plen;
  logic [7:0] tot_byte;
  assign rlen     = tcp_q ? ittl_pkg::ReplyLenTcp : ittl_pkg::ReplyLenShort;
  assign plen     = tcp_q ? ittl_pkg::PayLenTcp : ittl_pkg::PayLenShort;
  assign tot_byte = tcp_q ? 8'd68 : 8'd56;

  logic adv, out_free, issue;
  assign out_free = !out_valid_q || !out_stall_i;
  assign adv      = cmd_i.sum_run || (cmd_i.emit_run && out_free);
  assign issue    = (cmd_i.sum_run && (idx_q != plen)) || (cmd_i.emit_run && (idx_q != rlen));

  // Payload index -> store address.
  logic [6:0] jsel;
  logic [7:0] addr_full;
  always_comb begin
    if (cmd_i.emit_run) begin
      jsel = (out_free ? idx_q : s1_pos_q) - ittl_pkg::PayloadPos;
    end else begin
      jsel = idx_q;
    end
    if (jsel < ittl_pkg::IpLen) begin
      addr_full = {1'b0, ittl_pkg::EthLen + jsel};
    end else begin
      addr_full = {1'b0, l4off_q} + {1'b0, jsel} - {1'b0, ittl_pkg::IpLen};
    end
    rd_addr = addr_full[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (count_q < CapLimit)) begin
      mem[count_q[AW-1:0]] <= frame_byte_i;
    end
    rd_q <= mem[rd_addr];
  end

  // Fixed header fields, each captured at its own offset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int k = 0; k < 14; k++) begin
        if (count_q == 16'(k)) eth_q[k] <= frame_byte_i;
      end
      for (int k = 0; k < 4; k++) begin
        if (count_q == 16'(26 + k)) src_q[k] <= frame_byte_i;
      end
      if (count_q == 16'd14) ihl_q   <= frame_byte_i;
      if (count_q == 16'd18) id0_q   <= frame_byte_i;
      if (count_q == 16'd19) id1_q   <= frame_byte_i;
      if (count_q == 16'd22) ttl_q   <= frame_byte_i;
      if (count_q == 16'd23) proto_q <= frame_byte_i;
      if (frame_end_i) begin
        tcp_q   <= tcp_now;
        l4off_q <= ittl_pkg::EthLen + hl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      my_addr_q <= '0;
    end else begin
      if (cfg_valid_i) my_addr_q <= my_address_i;
      if (cmd_i.accept) begin
        if (frame_end_i) count_q <= '0;
        else if (count_q != 16'hffff) count_q <= count_q + 16'd1;
      end
    end
  end

  // IP header word for the running sum.
  logic [15:0] ip_word;
  always_comb begin
    unique case (idx_q[3:0])
      4'd0:    ip_word = {ittl_pkg::VerIhl, ittl_pkg::ReplyTos};
      4'd1:    ip_word = {8'h00, tot_byte};
      4'd2:    ip_word = {id0_q, id1_q};
      4'd4:    ip_word = {ittl_pkg::ReplyTtl, ittl_pkg::ProtoIcmp};
      4'd6:    ip_word = my_addr_q[31:16];
      4'd7:    ip_word = my_addr_q[15:0];
      4'd8:    ip_word = {src_q[0], src_q[1]};
      4'd9:    ip_word = {src_q[2], src_q[3]};
      default: ip_word = 16'h0000;
    endcase
  end

  logic [16:0] ip_sum, ic_sum;
  assign ip_sum = {1'b0, ipacc_q} + {1'b0, ip_word};
  assign ic_sum = {1'b0, icacc_q} + {1'b0, hi_q, rd_q};

  logic [15:0] ip_ck, ic_ck;
  assign ip_ck = ~ipacc_q;
  assign ic_ck = ~icacc_q;

  // Reply byte at stage-1 position.
  logic [7:0] rbyte;
  always_comb begin
    rbyte = 8'h00;
    if (s1_pos_q >= ittl_pkg::PayloadPos) begin
      rbyte = rd_q;
    end else if (s1_pos_q < 7'd6) begin
      unique case (s1_pos_q[2:0])
        3'd0: rbyte = eth_q[6];
        3'd1: rbyte = eth_q[7];
        3'd2: rbyte = eth_q[8];
        3'd3: rbyte = eth_q[9];
        3'd4: rbyte = eth_q[10];
        default: rbyte = eth_q[11];
      endcase
    end else begin
      unique case (s1_pos_q)
        7'd6:  rbyte = eth_q[0];
        7'd7:  rbyte = eth_q[1];
        7'd8:  rbyte = eth_q[2];
        7'd9:  rbyte = eth_q[3];
        7'd10: rbyte = eth_q[4];
        7'd11: rbyte = eth_q[5];
        7'd12: rbyte = 8'h08;
        7'd14: rbyte = ittl_pkg::VerIhl;
        7'd15: rbyte = ittl_pkg::ReplyTos;
        7'd17: rbyte = tot_byte;
        7'd18: rbyte = id0_q;
        7'd19: rbyte = id1_q;
        7'd22: rbyte = ittl_pkg::ReplyTtl;
        7'd23: rbyte = ittl_pkg::ProtoIcmp;
        7'd24: rbyte = ip_ck[15:8];
        7'd25: rbyte = ip_ck[7:0];
        7'd26: rbyte = my_addr_q[31:24];
        7'd27: rbyte = my_addr_q[23:16];
        7'd28: rbyte = my_addr_q[15:8];
        7'd29: rbyte = my_addr_q[7:0];
        7'd30: rbyte = src_q[0];
        7'd31: rbyte = src_q[1];
        7'd32: rbyte = src_q[2];
        7'd33: rbyte = src_q[3];
        7'd34: rbyte = ittl_pkg::IcmpTimeExceeded;
        7'd36: rbyte = ic_ck[15:8];
        7'd37: rbyte = ic_ck[7:0];
        default: rbyte = 8'h00;
      endcase
    end
  end

  logic [63:0] buf_next;
  logic        word_end, reply_last;
  always_comb begin
    buf_next = buf_q;
    buf_next[s1_pos_q[2:0]*8 +: 8] = rbyte;
  end
  assign reply_last = (s1_pos_q == rlen - 7'd1);
  assign word_end   = (s1_pos_q[2:0] == 3'd7) || reply_last;

  // Sequencing registers of the sum and emit phases.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_pos_q   <= '0;
    end else if (cmd_i.accept && frame_end_i) begin
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
    end else if (cmd_i.emit_start) begin
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      idx_q      <= idx_q + {6'd0, issue};
      s1_valid_q <= issue;
      s1_pos_q   <= idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && frame_end_i) begin
      ipacc_q <= '0;
      icacc_q <= {ittl_pkg::IcmpTimeExceeded, 8'h00};
    end else if (cmd_i.sum_run) begin
      if (issue && (idx_q < 7'd10)) ipacc_q <= ip_sum[15:0] + {15'd0, ip_sum[16]};
      if (s1_valid_q) begin
        if (!s1_pos_q[0]) hi_q <= rd_q;
        else icacc_q <= ic_sum[15:0] + {15'd0, ic_sum[16]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_start) begin
      buf_q <= '0;
    end else if (cmd_i.emit_run && out_free && s1_valid_q) begin
      buf_q <= word_end ? 64'd0 : buf_next;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pass_load || (cmd_i.emit_run && out_free && s1_valid_q && word_end)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pass_load) begin
      verdict_q <= 1'b0;
      word_q    <= '0;
      nbytes_q  <= '0;
      last_q    <= 1'b1;
    end else if (cmd_i.emit_run && out_free && s1_valid_q && word_end) begin
      verdict_q <= 1'b1;
      word_q    <= buf_next;
      nbytes_q  <= {1'b0, s1_pos_q[2:0]} + 4'd1;
      last_q    <= reply_last;
    end
  end

  assign status_o.reply     = reply_now;
  assign status_o.sum_done  = cmd_i.sum_run && s1_valid_q && (s1_pos_q == plen - 7'd1);
  assign status_o.emit_done = cmd_i.emit_run && out_free && s1_valid_q && reply_last;
  assign status_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign verdict_o     = verdict_q;
  assign reply_word_o  = word_q;
  assign valid_bytes_o = nbytes_q;
  assign last_item_o   = last_q;

endmodule

// File: hw/rtl/icmp_ttl_expired_responder.sv
// Top level of the ICMP time-exceeded responder.
// Depends on ittl_pkg, ittl_ctrl and ittl_dp.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   frame_byte_i, frame_end_i
//   out      source     out_valid_o / out_stall_i verdict_o, reply_word_o,
//                                                 valid_bytes_o, last_item_o
//   cfg      sink       cfg_valid_i / cfg_ready_o my_address_i
//
// Frame bytes transfer one per cycle while idle; the final byte decides. A pass verdict
// stalls the input until the output register is free, and is then loaded into it.
// A reply runs a checksum pass over the stored payload, then streams one byte a cycle
// while the output is not stalled, from the single store read port; the input stays
// stalled through both phases and every output stall.
// Reset clears control state and my_address; the store needs no clearing.
module icmp_ttl_expired_responder #(
  parameter int unsigned CAPTURE_BYTES = ittl_pkg::CaptureBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        verdict_o,
  output logic [63:0] reply_word_o,
  output logic [3:0]  valid_bytes_o,
  output logic        last_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] my_address_i
);

  ittl_pkg::cmd_t    cmd;
  ittl_pkg::status_t status;

  // The user writes configuration only while idle; the block does not enforce it and takes every transfer.
  assign cfg_ready_o = 1'b1;

  ittl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .frame_end_i (frame_end_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  ittl_dp #(
    .CAPTURE_BYTES (CAPTURE_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .frame_byte_i  (frame_byte_i),
    .frame_end_i   (frame_end_i),
    .cfg_valid_i   (cfg_valid_i),
    .my_address_i  (my_address_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .verdict_o     (verdict_o),
    .reply_word_o  (reply_word_o),
    .valid_bytes_o (valid_bytes_o),
    .last_item_o   (last_item_o)
  );

endmodule

// File: tb/tb_icmp_ttl_expired_responder.sv
// Testbench for the ICMP time-exceeded responder: drives random and directed
// Ethernet frames byte by byte, predicts the pass verdict or reply words.
// Depends on ittl_pkg and icmp_ttl_expired_responder.
module tb_icmp_ttl_expired_responder;

  typedef struct packed {
    logic        verdict;
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } reply_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  frame_byte_i = 8'd0;
  logic        frame_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        verdict_o;
  logic [63:0] reply_word_o;
  logic [3:0]  valid_bytes_o;
  logic        last_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] my_address_i = 32'd0;

  icmp_ttl_expired_responder uut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [7:0]  captured [ittl_pkg::CaptureBytesDef];
  logic [15:0] bytes_seen = 16'd0;
  logic [31:0] src_address = 32'd0;
  reply_item_t expected_items[$];

  int errors = 0;
  int frames_sent = 0;
  int replies_seen = 0;
  int passes_seen = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic logic [7:0] cap(input int idx);
    return (idx < ittl_pkg::CaptureBytesDef) ? captured[idx] : 8'd0;
  endfunction

  function automatic logic [15:0] ones_sum(input logic [7:0] b[], input int n);
    logic [31:0] s;
    s = 0;
    for (int i = 0; i + 1 < n; i += 2) s += {b[i], b[i+1]};
    while (s[31:16] != 0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    return ~s[15:0];
  endfunction

  // Advance the predictor by one frame byte; queue any resulting items.
  task automatic predict_byte(input logic [7:0] b, input logic fin);
    int len, ihl4, l4len, l4off, rlen, n, k;
    logic [7:0] r[];
    logic [7:0] ic[];
    logic [15:0] c;
    logic [63:0] w;
    if (bytes_seen < ittl_pkg::CaptureBytesDef) captured[bytes_seen] = b;
    if (bytes_seen != 16'hffff) bytes_seen++;
    if (!fin) return;
    len = bytes_seen;
    bytes_seen = 0;
    l4len = 0;
    l4off = 0;
    if (len >= 34 && cap(12) == 8'h08 && cap(13) == 8'h00 && cap(22) <= 1) begin
      if (cap(23) == ittl_pkg::ProtoTcp) l4len = 20;
      else if (cap(23) == ittl_pkg::ProtoUdp || cap(23) == ittl_pkg::ProtoIcmp) l4len = 8;
      if (l4len != 0) begin
        ihl4 = cap(14) % 16 * 4;
        l4off = 14 + ihl4;
        if (14 + (ihl4 < 20 ? 20 : ihl4) + l4len > len) l4len = 0;
      end
    end
    if (l4len == 0) begin
      expected_items.push_back('{1'b0, 64'd0, 4'd0, 1'b1});
      return;
    end
    rlen = 62 + l4len;
    r = new[96];
    foreach (r[i]) r[i] = 8'd0;
    for (int i = 0; i < 6; i++) begin
      r[i] = cap(6 + i);
      r[6 + i] = cap(i);
    end
    r[12] = 8'h08;
    r[14] = ittl_pkg::VerIhl;
    r[15] = ittl_pkg::ReplyTos;
    r[17] = 8'(48 + l4len);
    r[18] = cap(18);
    r[19] = cap(19);
    r[22] = ittl_pkg::ReplyTtl;
    r[23] = ittl_pkg::ProtoIcmp;
    {r[26], r[27], r[28], r[29]} = src_address;
    for (int i = 0; i < 4; i++) r[30 + i] = cap(26 + i);
    ic = new[20];
    for (int i = 0; i < 20; i++) ic[i] = r[14 + i];
    c = ones_sum(ic, 20);
    r[24] = c[15:8];
    r[25] = c[7:0];
    r[34] = ittl_pkg::IcmpTimeExceeded;
    for (int i = 0; i < 20; i++) r[42 + i] = cap(14 + i);
    for (int i = 0; i < l4len; i++) r[62 + i] = cap(l4off + i);
    ic = new[28 + l4len];
    for (int i = 0; i < 28 + l4len; i++) ic[i] = r[34 + i];
    c = ones_sum(ic, 28 + l4len);
    r[36] = c[15:8];
    r[37] = c[7:0];
    for (k = 0; k * 8 < rlen; k++) begin
      n = (rlen - k * 8 > 8) ? 8 : rlen - k * 8;
      w = 64'd0;
      for (int i = 0; i < n; i++) w[8*i +: 8] = r[k * 8 + i];
      expected_items.push_back('{1'b1, w, 4'(n), ((k + 1) * 8 >= rlen)});
    end
  endtask

  // Send one byte: random gap with valid low, hold until the transfer, then predict it.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 1)) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    frame_end_i  <= fin;
    do @(posedge clk_i); while (in_stall_o);
    predict_byte(b, fin);
  endtask

  task automatic send_frame(input logic [7:0] f[]);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
    frames_sent++;
  endtask

  // Build a frame that passes the early checks, with random content.
  function automatic void make_expired(output logic [7:0] f[], input logic [7:0] proto,
                                       input int ihl, input int len);
    f = new[len];
    foreach (f[i]) f[i] = 8'($urandom);
    f[12] = 8'h08;
    f[13] = 8'h00;
    f[14] = {4'($urandom), 4'(ihl)};
    f[22] = 8'($urandom_range(0, 1));
    f[23] = proto;
  endfunction

  function automatic int need_len(input logic [7:0] proto, input int ihl);
    int l4;
    l4 = (proto == ittl_pkg::ProtoTcp) ? 20 : 8;
    return 14 + ((ihl * 4 < 20) ? 20 : ihl * 4) + l4;
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk_i);
    // Allow the block to finish any work before the next register write.
    repeat (140) @(posedge clk_i);
  endtask

  task automatic write_address(input logic [31:0] a);
    cfg_valid_i  <= 1'b1;
    my_address_i <= a;
    do @(posedge clk_i); while (!cfg_ready_o);
    src_address = a;
    cfg_valid_i <= 1'b0;
  endtask

  // Directed frames: checksum carries with all-ones content, a UDP frame one
  // byte short, ICMP with IHL below 5, TTL 2, non-IPv4 ethertype, another
  // protocol, a 33-byte frame and a single-byte frame.
  task automatic test_directed();
    logic [7:0] f[];
    make_expired(f, ittl_pkg::ProtoTcp, 5, 54);
    foreach (f[i]) begin
      if (i != 12 && i != 13 && i != 14 && i != 23) f[i] = 8'hff;
    end
    f[22] = 8'd0;
    send_frame(f);
    make_expired(f, ittl_pkg::ProtoUdp, 5, 41);   send_frame(f);
    make_expired(f, ittl_pkg::ProtoIcmp, 0, 42);  send_frame(f);
    make_expired(f, ittl_pkg::ProtoUdp, 5, 42); f[22] = 8'd2;  send_frame(f);
    make_expired(f, ittl_pkg::ProtoUdp, 5, 42); f[13] = 8'h06; send_frame(f);
    make_expired(f, 8'd2, 5, 34);                 send_frame(f);
    make_expired(f, ittl_pkg::ProtoUdp, 5, 33);   send_frame(f);
    f = new[1]; f[0] = 8'hff;                     send_frame(f);
  endtask

  // Mostly well-formed expired frames, with noise frames mixed in.
  task automatic test_random(input int nbytes);
    logic [7:0] f[];
    logic [7:0] proto;
    int ihl, sent, pick;
    sent = 0;
    while (sent < nbytes) begin
      pick = $urandom_range(0, 9);
      case ($urandom_range(0, 2))
        0: proto = ittl_pkg::ProtoTcp;
        1: proto = ittl_pkg::ProtoUdp;
        default: proto = ittl_pkg::ProtoIcmp;
      endcase
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
      if (pick < 7) begin
        make_expired(f, proto, ihl, need_len(proto, ihl) + $urandom_range(0, 4));
      end else if (pick < 9) begin
        make_expired(f, proto, ihl, $urandom_range(30, need_len(proto, ihl)));
        if ($urandom_range(0, 1)) f[22] = 8'($urandom);
        if ($urandom_range(0, 1)) f[23] = 8'($urandom);
      end else begin
        f = new[$urandom_range(1, 20)];
        foreach (f[i]) f[i] = 8'($urandom);
      end
      send_frame(f);
      sent += f.size();
    end
  endtask

  // Result checker and receiver stall.
  int stall_left = 0;
  always @(posedge clk_i) begin
    reply_item_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{verdict_o, reply_word_o, valid_bytes_o, last_item_o};
        if (expected_items.size() == 0) begin
          report("result with no expectation waiting");
        end else begin
          want = expected_items.pop_front();
          if (got.verdict != want.verdict)
            report($sformatf("verdict %0d want %0d", got.verdict, want.verdict));
          if (got.word != want.word)
            report($sformatf("reply_word %h want %h", got.word, want.word));
          if (got.nbytes != want.nbytes)
            report($sformatf("valid_bytes %0d want %0d", got.nbytes, want.nbytes));
          if (got.last != want.last)
            report($sformatf("last_item %0d want %0d", got.last, want.last));
          if (got.last) begin
            if (got.verdict) replies_seen++;
            else passes_seen++;
          end
        end
        // Draw a new stall length for the next item.
        stall_left = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 15);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  // Watchdog: stop when no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000 && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired with %0d items outstanding", expected_items.size());
      $display("icmp_ttl_expired_responder test failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain();
    write_address(32'hffffffff);
    test_random(30);
    drain();
    $display("covered %0d frames: %0d replies, %0d pass verdicts", frames_sent,
             replies_seen, passes_seen);
    if (errors == 0 && expected_items.size() == 0) begin
      $display("icmp_ttl_expired_responder test passed");
    end else begin
      $display("icmp_ttl_expired_responder test failed");
    end
    $finish;
  end

endmodule
